>>> hw/rtl/wdsr_pkg.sv
package wdsr_pkg;

	localparam int unsigned INCIDENT_DEPTH_DEF = 4;
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned S_TDATA_W = 80;
	localparam int unsigned M_TDATA_W = 64;
	localparam int unsigned RESULT_W = 57;

	localparam logic signed [8:0] SPEED_CAP = 9'sd249;

	localparam logic [9:0] CURRENT_LIMIT_RST = 10'd512;
	localparam logic [15:0] COMMAND_TIMEOUT_RST = 16'd1000;
	localparam logic [15:0] INCIDENT_WINDOW_RST = 16'd1000;

	typedef enum logic [2:0] {
		OP_TICK = 3'd0,
		OP_DRIVE = 3'd1,
		OP_STOP = 3'd2,
		OP_LEFT_EDGE = 3'd3,
		OP_RIGHT_EDGE = 3'd4
	} op_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_CURRENT_LIMIT = 3'd0,
		REG_COMMAND_TIMEOUT = 3'd1,
		REG_INCIDENT_WINDOW = 3'd2,
		REG_LEFT_REVERSED = 3'd3,
		REG_RIGHT_REVERSED = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic [9:0] current_limit;
		logic [15:0] command_timeout_ms;
		logic [15:0] incident_window_ms;
		logic left_encoder_reversed;
		logic right_encoder_reversed;
	} cfg_t;

	typedef struct packed {
		logic signed [10:0] right_request;
		logic signed [10:0] left_request;
		logic bumper_right;
		logic bumper_left;
		logic [9:0] right_current;
		logic [9:0] left_current;
		logic [31:0] time_ms;
		logic [2:0] op;
	} item_t;

	// first member is the msb, so the packed order matches tdata from the lsb up
	typedef struct packed {
		logic signed [15:0] right_ticks;
		logic signed [15:0] left_ticks;
		logic bumper_hold;
		logic locked_out;
		logic derated;
		logic right_backward;
		logic right_forward;
		logic left_backward;
		logic left_forward;
		logic signed [8:0] right_speed;
		logic signed [8:0] left_speed;
	} result_t;

endpackage

>>> hw/rtl/wdsr_cfg.sv
module wdsr_cfg (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [wdsr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [wdsr_pkg::CFG_DATA_W-1:0] cfg_data,
	output wdsr_pkg::cfg_t cfg
);
	import wdsr_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.current_limit <= CURRENT_LIMIT_RST;
			cfg_q.command_timeout_ms <= COMMAND_TIMEOUT_RST;
			cfg_q.incident_window_ms <= INCIDENT_WINDOW_RST;
			cfg_q.left_encoder_reversed <= 1'b0;
			cfg_q.right_encoder_reversed <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CURRENT_LIMIT: cfg_q.current_limit <= cfg_data[9:0];
				REG_COMMAND_TIMEOUT: cfg_q.command_timeout_ms <= cfg_data;
				REG_INCIDENT_WINDOW: cfg_q.incident_window_ms <= cfg_data;
				REG_LEFT_REVERSED: cfg_q.left_encoder_reversed <= cfg_data[0];
				REG_RIGHT_REVERSED: cfg_q.right_encoder_reversed <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

>>> hw/rtl/wdsr_core.sv
module wdsr_core #(
	parameter int unsigned INCIDENT_DEPTH = wdsr_pkg::INCIDENT_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic advance,
	input wdsr_pkg::item_t item,
	input wdsr_pkg::cfg_t cfg,
	output wdsr_pkg::result_t result
);
	import wdsr_pkg::*;

	// four fifths of a speed, truncated toward zero; (x * 205) >> 10 is x / 5 for x < 1024
	function automatic logic signed [8:0] derate(input logic signed [8:0] t);
		logic [8:0] mag;
		logic [17:0] prod;
		logic [8:0] q;
		mag = t[8] ? 9'(-t) : 9'(t);
		prod = {mag, 2'b00} * 18'd205;
		q = {1'b0, prod[17:10]};
		return t[8] ? $signed(9'(-q)) : $signed(q);
	endfunction

	function automatic logic signed [8:0] cap_speed(input logic signed [10:0] v);
		if (v > 11'(SPEED_CAP)) return SPEED_CAP;
		if (v < -11'(SPEED_CAP)) return -SPEED_CAP;
		return v[8:0];
	endfunction

	function automatic logic signed [8:0] ramp(input logic signed [8:0] cur,
			input logic signed [8:0] tgt);
		if (tgt < cur) return cur - 9'sd1;
		if (tgt > cur) return cur + 9'sd1;
		return cur;
	endfunction

	logic signed [8:0] target_left_q, target_right_q, speed_left_q, speed_right_q;
	logic signed [8:0] target_left_d, target_right_d, speed_left_d, speed_right_d;
	logic [31:0] last_command_time_q, last_command_time_d;
	logic [31:0] incident_q [INCIDENT_DEPTH];
	logic [31:0] incident_d [INCIDENT_DEPTH];
	logic [31:0] incident_shift [INCIDENT_DEPTH];
	logic signed [1:0] dir_left_q, dir_right_q, dir_left_d, dir_right_d;
	logic signed [15:0] ticks_left_q, ticks_right_q, ticks_left_d, ticks_right_d;
	logic overcurrent, timed_out, incident_lock;
	logic derated, locked_out, bumper_hold;
	logic [31:0] since_command, since_incident;

	assign overcurrent = (item.left_current > cfg.current_limit)
		|| (item.right_current > cfg.current_limit);

	// incident log as it stands after this tick's shift
	assign incident_shift[0] = item.time_ms;
	for (genvar i = 1; i < INCIDENT_DEPTH; i++) begin : g_shift
		assign incident_shift[i] = incident_q[i-1];
	end

	for (genvar i = 0; i < INCIDENT_DEPTH; i++) begin : g_inc
		assign incident_d[i] = (item.op == OP_TICK && overcurrent) ? incident_shift[i]
			: incident_q[i];
	end

	assign since_command = item.time_ms - last_command_time_q;
	assign since_incident = item.time_ms - incident_d[INCIDENT_DEPTH-1];
	assign timed_out = since_command > {16'd0, cfg.command_timeout_ms};
	assign incident_lock = (item.time_ms > {16'd0, cfg.incident_window_ms})
		&& (since_incident < {16'd0, cfg.incident_window_ms});

	always_comb begin
		target_left_d = target_left_q;
		target_right_d = target_right_q;
		speed_left_d = speed_left_q;
		speed_right_d = speed_right_q;
		last_command_time_d = last_command_time_q;
		dir_left_d = dir_left_q;
		dir_right_d = dir_right_q;
		ticks_left_d = ticks_left_q;
		ticks_right_d = ticks_right_q;
		derated = 1'b0;
		locked_out = 1'b0;
		bumper_hold = 1'b0;
		case (item.op)
			OP_TICK: begin
				if (overcurrent) begin
					derated = 1'b1;
					target_left_d = derate(target_left_q);
					target_right_d = derate(target_right_q);
				end
				if (timed_out || incident_lock) begin
					locked_out = 1'b1;
					speed_left_d = '0;
					speed_right_d = '0;
					target_left_d = '0;
					target_right_d = '0;
				end
				speed_left_d = ramp(speed_left_d, target_left_d);
				speed_right_d = ramp(speed_right_d, target_right_d);
				// pressed bumper reads as level 0
				if (!item.bumper_left || !item.bumper_right) begin
					bumper_hold = 1'b1;
					if (speed_left_d > 0) speed_left_d = '0;
					if (speed_right_d > 0) speed_right_d = '0;
					if (target_left_d > 0) target_left_d = '0;
					if (target_right_d > 0) target_right_d = '0;
				end
				if (speed_left_d > 0) dir_left_d = 2'sd1;
				if (speed_left_d < 0) dir_left_d = -2'sd1;
				if (speed_right_d > 0) dir_right_d = 2'sd1;
				if (speed_right_d < 0) dir_right_d = -2'sd1;
			end
			OP_DRIVE: begin
				last_command_time_d = item.time_ms;
				target_left_d = cap_speed(item.left_request);
				target_right_d = cap_speed(item.right_request);
			end
			OP_STOP: begin
				speed_left_d = '0;
				speed_right_d = '0;
				target_left_d = '0;
				target_right_d = '0;
			end
			OP_LEFT_EDGE: begin
				if (cfg.left_encoder_reversed)
					ticks_left_d = ticks_left_q - 16'(dir_left_q);
				else
					ticks_left_d = ticks_left_q + 16'(dir_left_q);
			end
			OP_RIGHT_EDGE: begin
				if (cfg.right_encoder_reversed)
					ticks_right_d = ticks_right_q - 16'(dir_right_q);
				else
					ticks_right_d = ticks_right_q + 16'(dir_right_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_left_q <= '0;
			target_right_q <= '0;
			speed_left_q <= '0;
			speed_right_q <= '0;
			last_command_time_q <= '0;
			dir_left_q <= '0;
			dir_right_q <= '0;
			ticks_left_q <= '0;
			ticks_right_q <= '0;
			for (int i = 0; i < INCIDENT_DEPTH; i++) incident_q[i] <= '0;
		end else if (advance) begin
			target_left_q <= target_left_d;
			target_right_q <= target_right_d;
			speed_left_q <= speed_left_d;
			speed_right_q <= speed_right_d;
			last_command_time_q <= last_command_time_d;
			dir_left_q <= dir_left_d;
			dir_right_q <= dir_right_d;
			ticks_left_q <= ticks_left_d;
			ticks_right_q <= ticks_right_d;
			for (int i = 0; i < INCIDENT_DEPTH; i++) incident_q[i] <= incident_d[i];
		end
	end

	always_comb begin
		result.left_speed = speed_left_d;
		result.right_speed = speed_right_d;
		result.left_forward = speed_left_d > 0;
		result.left_backward = speed_left_d < 0;
		result.right_forward = speed_right_d > 0;
		result.right_backward = speed_right_d < 0;
		result.derated = derated;
		result.locked_out = locked_out;
		result.bumper_hold = bumper_hold;
		result.left_ticks = ticks_left_d;
		result.right_ticks = ticks_right_d;
	end

endmodule

>>> hw/rtl/wheel_drive_safety_ramp.sv
// a transferred item lands in the input stage, and its result is registered into the
// output stage when the input stage advances, which raises m_tvalid
// throughput: one item per cycle unless m_tready stalls the output, set by the core's state update
// reset: arst_n clears wheel state, incident log, tick counts and the valid flags of both stages,
// and returns the configuration registers to their defaults
module wheel_drive_safety_ramp #(
	parameter int unsigned INCIDENT_DEPTH = wdsr_pkg::INCIDENT_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// time_ms, left_current, right_current, bumper_left, bumper_right,
	// left_request, right_request, zero fill
	input logic [wdsr_pkg::S_TDATA_W-1:0] s_tdata,
	// op
	input logic [2:0] s_tuser,
	output logic m_tvalid,
	input logic m_tready,
	// left_speed, right_speed, left_forward, left_backward, right_forward,
	// right_backward, derated, locked_out, bumper_hold, left_ticks, right_ticks, zero fill
	output logic [wdsr_pkg::M_TDATA_W-1:0] m_tdata,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [wdsr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [wdsr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import wdsr_pkg::*;

	cfg_t cfg;
	item_t item_s1;
	logic valid_s1;
	logic advance;
	result_t result;
	result_t result_q;

	wdsr_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	// the input stage moves on whenever the result register is free or being drained
	assign advance = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= {s_tdata[75:0], s_tuser};
		end
	end

	wdsr_core #(
		.INCIDENT_DEPTH(INCIDENT_DEPTH)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.item(item_s1),
		.cfg(cfg),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign m_tdata = {{(M_TDATA_W - RESULT_W){1'b0}}, result_q};

	a_speed_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (result_q.left_speed <= SPEED_CAP && result_q.left_speed >= -SPEED_CAP
			&& result_q.right_speed <= SPEED_CAP && result_q.right_speed >= -SPEED_CAP))
		else $error("speed beyond cap");

	a_pins_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(result_q.left_forward && result_q.left_backward)
			&& !(result_q.right_forward && result_q.right_backward))
		else $error("forward and backward both set");

	a_lockout_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && result_q.locked_out) |->
			(result_q.left_speed == 0 && result_q.right_speed == 0))
		else $error("lockout left a wheel moving");

	a_stage_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(item_s1)))
		else $error("stalled input stage lost its item");

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;
	import wdsr_pkg::*;

	localparam int unsigned INCIDENT_DEPTH = INCIDENT_DEPTH_DEF;
	localparam int N_DIRECTED = 25;
	localparam int N_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 191;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 600000;
	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_LAST = 3'd7;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd6;

	typedef struct {
		logic [2:0] op;
		logic [31:0] time_ms;
		logic [9:0] cur_l;
		logic [9:0] cur_r;
		logic bump_l;
		logic bump_r;
		logic signed [10:0] req_l;
		logic signed [10:0] req_r;
	} wheel_cmd_t;

	typedef struct {
		wheel_cmd_t cmd;
		bit typed;
		result_t want;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	// time_ms, left_current, right_current, bumper_left, bumper_right,
	// left_request, right_request, zero fill
	logic [S_TDATA_W-1:0] s_tdata;
	// op
	logic [2:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	// left_speed, right_speed, left_forward, left_backward, right_forward,
	// right_backward, derated, locked_out, bumper_hold, left_ticks, right_ticks, zero fill
	logic [M_TDATA_W-1:0] m_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	wheel_drive_safety_ramp #(
		.INCIDENT_DEPTH(INCIDENT_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// predicted wheel state and registers
	logic [9:0] lim_q = CURRENT_LIMIT_RST;
	logic [15:0] timeout_q = COMMAND_TIMEOUT_RST;
	logic [15:0] window_q = INCIDENT_WINDOW_RST;
	logic rev_l = 1'b0;
	logic rev_r = 1'b0;
	logic signed [8:0] tgt_l = '0;
	logic signed [8:0] tgt_r = '0;
	logic signed [8:0] spd_l = '0;
	logic signed [8:0] spd_r = '0;
	logic [31:0] last_drive_ms = '0;
	logic [31:0] incident_log [INCIDENT_DEPTH] = '{default: '0};
	logic signed [1:0] dir_l = '0;
	logic signed [1:0] dir_r = '0;
	logic [15:0] cnt_l = '0;
	logic [15:0] cnt_r = '0;

	result_t wheel_state_q[$];
	bit typed_q[$];
	result_t typed_want_q[$];
	int sent_count = 0;
	int checked_count = 0;
	int mismatch_count = 0;
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	bit hold_request = 1'b0;
	directed_row_t directed [N_DIRECTED];

	function automatic logic signed [8:0] cap_request(logic signed [10:0] req);
		if (req > SPEED_CAP) return SPEED_CAP;
		if (req < -SPEED_CAP) return -SPEED_CAP;
		return req[8:0];
	endfunction

	// 4/5 with truncation toward zero
	function automatic logic signed [8:0] derate(logic signed [8:0] v);
		int w;
		w = v;
		w = (w * 4) / 5;
		return w[8:0];
	endfunction

	function automatic logic signed [8:0] step_toward(logic signed [8:0] cur,
			logic signed [8:0] tgt);
		if (tgt < cur) return cur - 9'sd1;
		if (tgt > cur) return cur + 9'sd1;
		return cur;
	endfunction

	function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] v);
		case (idx)
			REG_CURRENT_LIMIT: lim_q = v[9:0];
			REG_COMMAND_TIMEOUT: timeout_q = v;
			REG_INCIDENT_WINDOW: window_q = v;
			REG_LEFT_REVERSED: rev_l = v[0];
			REG_RIGHT_REVERSED: rev_r = v[0];
			default: ;
		endcase
	endfunction

	function automatic result_t apply_item(wheel_cmd_t c);
		result_t r;
		bit der;
		bit lock;
		bit hold;
		logic [31:0] since_drive;
		logic [31:0] since_oldest;
		der = 1'b0;
		lock = 1'b0;
		hold = 1'b0;
		case (c.op)
			OP_TICK: begin
				if (c.cur_l > lim_q || c.cur_r > lim_q) begin
					der = 1'b1;
					tgt_l = derate(tgt_l);
					tgt_r = derate(tgt_r);
					for (int i = INCIDENT_DEPTH - 1; i > 0; i--)
						incident_log[i] = incident_log[i-1];
					incident_log[0] = c.time_ms;
				end
				since_drive = c.time_ms - last_drive_ms;
				since_oldest = c.time_ms - incident_log[INCIDENT_DEPTH-1];
				if (since_drive > {16'd0, timeout_q} ||
						(c.time_ms > {16'd0, window_q} && since_oldest < {16'd0, window_q})) begin
					lock = 1'b1;
					spd_l = '0;
					spd_r = '0;
					tgt_l = '0;
					tgt_r = '0;
				end
				spd_r = step_toward(spd_r, tgt_r);
				spd_l = step_toward(spd_l, tgt_l);
				if (!c.bump_l || !c.bump_r) begin
					hold = 1'b1;
					if (spd_r > 0) spd_r = '0;
					if (spd_l > 0) spd_l = '0;
					if (tgt_r > 0) tgt_r = '0;
					if (tgt_l > 0) tgt_l = '0;
				end
				if (spd_l > 0) dir_l = 2'sd1;
				else if (spd_l < 0) dir_l = -2'sd1;
				if (spd_r > 0) dir_r = 2'sd1;
				else if (spd_r < 0) dir_r = -2'sd1;
			end
			OP_DRIVE: begin
				last_drive_ms = c.time_ms;
				tgt_l = cap_request(c.req_l);
				tgt_r = cap_request(c.req_r);
			end
			OP_STOP: begin
				spd_l = '0;
				spd_r = '0;
				tgt_l = '0;
				tgt_r = '0;
			end
			OP_LEFT_EDGE:
				cnt_l = rev_l ? cnt_l - {{14{dir_l[1]}}, dir_l} : cnt_l + {{14{dir_l[1]}}, dir_l};
			OP_RIGHT_EDGE:
				cnt_r = rev_r ? cnt_r - {{14{dir_r[1]}}, dir_r} : cnt_r + {{14{dir_r[1]}}, dir_r};
			default: ;
		endcase
		r.left_speed = spd_l;
		r.right_speed = spd_r;
		r.left_forward = spd_l > 0;
		r.left_backward = spd_l < 0;
		r.right_forward = spd_r > 0;
		r.right_backward = spd_r < 0;
		r.derated = der;
		r.locked_out = lock;
		r.bumper_hold = hold;
		r.left_ticks = cnt_l;
		r.right_ticks = cnt_r;
		return r;
	endfunction

	function automatic wheel_cmd_t wheel_cmd(logic [2:0] op, logic [31:0] t, int cl, int cr,
			bit bl, bit br, int lr, int rr);
		wheel_cmd_t c;
		c.op = op;
		c.time_ms = t;
		c.cur_l = 10'(cl);
		c.cur_r = 10'(cr);
		c.bump_l = bl;
		c.bump_r = br;
		c.req_l = 11'(lr);
		c.req_r = 11'(rr);
		return c;
	endfunction

	function automatic result_t wheel_state(int ls, int rs, int lt, int rt,
			bit der, bit lock, bit hold);
		result_t r;
		r.left_speed = 9'(ls);
		r.right_speed = 9'(rs);
		r.left_forward = ls > 0;
		r.left_backward = ls < 0;
		r.right_forward = rs > 0;
		r.right_backward = rs < 0;
		r.derated = der;
		r.locked_out = lock;
		r.bumper_hold = hold;
		r.left_ticks = 16'(lt);
		r.right_ticks = 16'(rt);
		return r;
	endfunction

	function automatic string show(result_t r);
		return $sformatf("spd %0d/%0d fwd %b%b back %b%b der %b lock %b hold %b ticks %0d/%0d",
			r.left_speed, r.right_speed, r.left_forward, r.right_forward, r.left_backward,
			r.right_backward, r.derated, r.locked_out, r.bumper_hold, r.left_ticks,
			r.right_ticks);
	endfunction

	// mostly plausible traffic: small time steps, frequent drive commands
	function automatic wheel_cmd_t random_cmd(inout logic [31:0] now_ms);
		wheel_cmd_t c;
		int r;
		int cur_top;
		r = $urandom_range(0, 99);
		if (r < 2) now_ms = $urandom();
		else if (r < 7) now_ms += $urandom_range(0, 2500);
		else now_ms += $urandom_range(0, 30);
		c.time_ms = now_ms;
		r = $urandom_range(0, 99);
		if (r < 46) c.op = OP_TICK;
		else if (r < 62) c.op = OP_DRIVE;
		else if (r < 65) c.op = OP_STOP;
		else if (r < 79) c.op = OP_LEFT_EDGE;
		else if (r < 93) c.op = OP_RIGHT_EDGE;
		else if (r < 96) c.op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
		else c.op = OP_TICK;
		cur_top = (lim_q * 3) / 4;
		c.cur_l = ($urandom_range(0, 99) < 6) ? 10'($urandom_range(0, 1023))
			: 10'($urandom_range(0, cur_top));
		c.cur_r = ($urandom_range(0, 99) < 6) ? 10'($urandom_range(0, 1023))
			: 10'($urandom_range(0, cur_top));
		c.bump_l = $urandom_range(0, 99) >= 5;
		c.bump_r = $urandom_range(0, 99) >= 5;
		c.req_l = ($urandom_range(0, 3) == 0) ? 11'($urandom()) : 11'($urandom_range(0, 560) - 280);
		c.req_r = ($urandom_range(0, 3) == 0) ? 11'($urandom()) : 11'($urandom_range(0, 560) - 280);
		return c;
	endfunction

	task automatic send_cmd(wheel_cmd_t c, bit typed, result_t want);
		typed_q.push_back(typed);
		typed_want_q.push_back(want);
		if (tx_idle_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= c.op;
		s_tdata <= {4'b0, c.req_r, c.req_l, c.bump_r, c.bump_l, c.cur_r, c.cur_l, c.time_ms};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent_count++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (checked_count < sent_count) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// valid stays high across back-to-back writes, the caller lowers it
	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic configure_phase(int p);
		logic [9:0] lim;
		logic [15:0] tmo;
		logic [15:0] win;
		logic lr;
		logic rr;
		case (p)
			0, 7: begin
				lim = CURRENT_LIMIT_RST;
				tmo = COMMAND_TIMEOUT_RST;
				win = INCIDENT_WINDOW_RST;
				lr = 1'b0;
				rr = 1'b0;
			end
			1: begin
				lim = '0;
				tmo = 16'hFFFF;
				win = 16'hFFFF;
				lr = 1'b1;
				rr = 1'b0;
			end
			2: begin
				lim = 10'h3FF;
				tmo = '0;
				win = '0;
				lr = 1'b0;
				rr = 1'b1;
			end
			4: begin
				lim = 10'd300;
				tmo = 16'd200;
				win = 16'd3000;
				lr = 1'b1;
				rr = 1'b1;
			end
			default: begin
				lim = 10'($urandom_range(200, 1023));
				tmo = 16'($urandom_range(50, 5000));
				win = 16'($urandom_range(0, 5000));
				lr = 1'($urandom());
				rr = 1'($urandom());
			end
		endcase
		// unused upper data bits carry noise
		write_reg(REG_CURRENT_LIMIT, {6'($urandom()), lim});
		write_reg(REG_COMMAND_TIMEOUT, tmo);
		write_reg(REG_INCIDENT_WINDOW, win);
		write_reg(REG_LEFT_REVERSED, {15'($urandom()), lr});
		write_reg(REG_RIGHT_REVERSED, {15'($urandom()), rr});
		if (p == 0) write_reg(REG_SPARE, 16'($urandom()));
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		logic [31:0] now_ms;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		arst_n <= 1'b0;

		directed[0] = '{wheel_cmd(OP_TICK, 32'd0, 0, 0, 1, 1, 0, 0), 1'b1,
			wheel_state(0, 0, 0, 0, 0, 0, 0)};
		// edge before any direction is known leaves the count alone
		directed[1] = '{wheel_cmd(OP_LEFT_EDGE, 32'd5, 0, 0, 1, 1, 0, 0), 1'b1,
			wheel_state(0, 0, 0, 0, 0, 0, 0)};
		directed[2] = '{wheel_cmd(OP_DRIVE, 32'd10, 0, 0, 1, 1, 1023, -1024), 1'b1,
			wheel_state(0, 0, 0, 0, 0, 0, 0)};
		directed[3] = '{wheel_cmd(OP_TICK, 32'd20, 0, 0, 1, 1, 0, 0), 1'b1,
			wheel_state(1, -1, 0, 0, 0, 0, 0)};
		directed[4] = '{wheel_cmd(OP_TICK, 32'd30, 1023, 0, 1, 1, 0, 0), 1'b1,
			wheel_state(2, -2, 0, 0, 1, 0, 0)};
		directed[5] = '{wheel_cmd(OP_LEFT_EDGE, 32'd31, 0, 0, 1, 1, 0, 0), 1'b1,
			wheel_state(2, -2, 1, 0, 0, 0, 0)};
		directed[6] = '{wheel_cmd(OP_RIGHT_EDGE, 32'd32, 0, 0, 1, 1, 0, 0), 1'b1,
			wheel_state(2, -2, 1, -1, 0, 0, 0)};
		// current equal to the limit is not overcurrent
		directed[7] = '{wheel_cmd(OP_TICK, 32'd40, 512, 512, 1, 1, 0, 0), 1'b0, '0};
		directed[8] = '{wheel_cmd(OP_TICK, 32'd50, 0, 513, 1, 1, 0, 0), 1'b0, '0};
		directed[9] = '{wheel_cmd(OP_TICK, 32'd60, 0, 0, 0, 1, 0, 0), 1'b0, '0};
		directed[10] = '{wheel_cmd(OP_TICK, 32'd70, 0, 0, 1, 0, 0, 0), 1'b0, '0};
		directed[11] = '{wheel_cmd(OP_DRIVE, 32'd80, 0, 0, 1, 1, 250, -249), 1'b0, '0};
		directed[12] = '{wheel_cmd(OP_TICK, 32'd90, 0, 0, 1, 1, 0, 0), 1'b0, '0};
		directed[13] = '{wheel_cmd(OP_STOP, 32'd95, 0, 0, 1, 1, 0, 0), 1'b1,
			wheel_state(0, 0, 1, -1, 0, 0, 0)};
		directed[14] = '{wheel_cmd(OP_SPARE_FIRST, 32'd96, 1023, 1023, 0, 0, 1023, 1023), 1'b1,
			wheel_state(0, 0, 1, -1, 0, 0, 0)};
		// command timeout
		directed[15] = '{wheel_cmd(OP_TICK, 32'd1200, 0, 0, 1, 1, 0, 0), 1'b1,
			wheel_state(0, 0, 1, -1, 0, 1, 0)};
		directed[16] = '{wheel_cmd(OP_DRIVE, 32'd1210, 0, 0, 1, 1, -250, 249), 1'b1,
			wheel_state(0, 0, 1, -1, 0, 0, 0)};
		directed[17] = '{wheel_cmd(OP_TICK, 32'd2210, 0, 0, 1, 1, 0, 0), 1'b0, '0};
		directed[18] = '{wheel_cmd(OP_TICK, 32'd2211, 0, 0, 1, 1, 0, 0), 1'b0, '0};
		// fill the incident log until its oldest entry falls inside the window
		directed[19] = '{wheel_cmd(OP_DRIVE, 32'd2300, 0, 0, 1, 1, 100, 100), 1'b0, '0};
		directed[20] = '{wheel_cmd(OP_TICK, 32'd2310, 600, 0, 1, 1, 0, 0), 1'b0, '0};
		directed[21] = '{wheel_cmd(OP_TICK, 32'd2320, 0, 1023, 1, 1, 0, 0), 1'b0, '0};
		directed[22] = '{wheel_cmd(OP_TICK, 32'd2330, 1023, 1023, 1, 1, 0, 0), 1'b0, '0};
		directed[23] = '{wheel_cmd(OP_TICK, 32'd2340, 700, 0, 1, 1, 0, 0), 1'b0, '0};
		directed[24] = '{wheel_cmd(OP_TICK, 32'hFFFF_FFFF, 1023, 1023, 0, 0, 0, 0), 1'b0, '0};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < N_DIRECTED; k++)
			send_cmd(directed[k].cmd, directed[k].typed, directed[k].want);

		for (int p = 0; p < N_PHASES; p++) begin
			drain_results();
			configure_phase(p);
			tx_idle_on = (p != 6 && p != 7);
			rx_idle_on = (p != 5 && p != 7);
			if (p == 3) hold_request = 1'b1;
			case (p)
				0: now_ms = 32'd2400;
				2: now_ms = 32'hFFFF_F800;
				default: now_ms = $urandom();
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_cmd(random_cmd(now_ms), 1'b0, '0);
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && wheel_state_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin : sink
		m_tready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_request) begin
				// long back-pressure so the block fills up and stalls its input
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : scoreboard
		wheel_cmd_t c;
		result_t want;
		result_t got;
		result_t typed_want;
		bit typed;
		string bad;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
			if (s_tvalid && s_tready) begin
				c.op = s_tuser;
				c.time_ms = s_tdata[31:0];
				c.cur_l = s_tdata[41:32];
				c.cur_r = s_tdata[51:42];
				c.bump_l = s_tdata[52];
				c.bump_r = s_tdata[53];
				c.req_l = s_tdata[64:54];
				c.req_r = s_tdata[75:65];
				typed = typed_q.pop_front();
				typed_want = typed_want_q.pop_front();
				want = apply_item(c);
				if (typed) want = typed_want;
				wheel_state_q.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata[RESULT_W-1:0]);
				if (wheel_state_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: result transfer with nothing pending: %s", $time, show(got));
				end else begin
					want = wheel_state_q.pop_front();
					checked_count++;
					bad = "";
					if (got.left_speed !== want.left_speed) bad = {bad, " left_speed"};
					if (got.right_speed !== want.right_speed) bad = {bad, " right_speed"};
					if (got.left_forward !== want.left_forward) bad = {bad, " left_forward"};
					if (got.left_backward !== want.left_backward) bad = {bad, " left_backward"};
					if (got.right_forward !== want.right_forward) bad = {bad, " right_forward"};
					if (got.right_backward !== want.right_backward) bad = {bad, " right_backward"};
					if (got.derated !== want.derated) bad = {bad, " derated"};
					if (got.locked_out !== want.locked_out) bad = {bad, " locked_out"};
					if (got.bumper_hold !== want.bumper_hold) bad = {bad, " bumper_hold"};
					if (got.left_ticks !== want.left_ticks) bad = {bad, " left_ticks"};
					if (got.right_ticks !== want.right_ticks) bad = {bad, " right_ticks"};
					if (bad != "") begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("%0t: mismatch in%s\n  expected %s\n  actual   %s",
								$time, bad, show(want), show(got));
					end
				end
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

endmodule
